[hw/rtl/consistent_hash_ring_router_core_macros.svh]
// ---------------------------------------------------------------------------
// consistent hash ring router assertion macros
// shared property forms for the ring controller checks
// ---------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_ROUTER_CORE_MACROS_SVH
`define CONSISTENT_HASH_RING_ROUTER_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define CHRR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("consistent hash ring: same-cycle check failed");

// consequent in the cycle after the antecedent
`define CHRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("consistent hash ring: next-cycle check failed");

`endif

[hw/rtl/chrr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// consistent hash ring router package
// sizes, types and helpers shared by the ring router modules
// ---------------------------------------------------------------------------
package chrr_pkg;

    localparam int RingPositions = 360;
    localparam int ServerIdBits  = 8;
    localparam int HashMult      = 31;

    // fixed port widths
    localparam int KeyCharBits   = 8;
    localparam int SidPortBits   = 8;
    localparam int PosPortBits   = 9;

    localparam int PosBits       = $clog2(RingPositions);

    // running hash sum before reduction
    localparam int MaxHashSum    = (RingPositions - 1) * HashMult + (1 << KeyCharBits) - 1;
    localparam int HashSumBits   = $clog2(MaxHashSum + 1);
    localparam int HashSteps     = $clog2(MaxHashSum / RingPositions + 1);

    // occupancy is kept as words of RowBits slots
    localparam int RowIdxBits    = 5;
    localparam int RowBits       = 1 << RowIdxBits;
    localparam int NumRows       = (RingPositions + RowBits - 1) / RowBits;
    localparam int RowAddrBits   = (NumRows > 1) ? $clog2(NumRows) : 1;

    typedef logic [PosBits-1:0]      t_pos;
    typedef logic [ServerIdBits-1:0] t_sid;
    typedef logic [HashSumBits-1:0]  t_hash_sum;
    typedef logic [RowBits-1:0]      t_row_word;
    typedef logic [RowIdxBits-1:0]   t_row_bit;
    typedef logic [RowAddrBits-1:0]  t_row;
    typedef logic [RowAddrBits:0]    t_row_cand;
    typedef logic [NumRows-1:0]      t_summary;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ROW2,
        ST_SRV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic found;
        t_sid target;
        t_pos pos;
    } t_result;

    function automatic t_row_bit first_set(input t_row_word v);
        t_row_bit idx;
        idx = '0;
        for (int i = RowBits - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = t_row_bit'(i);
            end
        end
        return idx;
    endfunction

    function automatic t_row pos_row(input t_pos p);
        return t_row'(p >> RowIdxBits);
    endfunction

    function automatic t_row_bit pos_bit(input t_pos p);
        return t_row_bit'(p);
    endfunction

    function automatic t_pos row_pos(input t_row r, input t_row_bit b);
        return t_pos'({r, b});
    endfunction

endpackage
`default_nettype wire

[hw/rtl/chrr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// generic ram
// one write port, one read port, read data registered
// ---------------------------------------------------------------------------
module chrr_ram #(
    parameter int Width    = 8,
    parameter int Depth    = 16,
    parameter int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AddrBits-1:0] i_waddr,
    input  logic [Width-1:0]    i_wdata,
    input  logic [AddrBits-1:0] i_raddr,
    output logic [Width-1:0]    o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/chrr_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ring router key hash
// running hash h = (h * 31 + byte) mod ring size, cleared after the last byte
// ---------------------------------------------------------------------------
module chrr_hash (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [chrr_pkg::KeyCharBits-1:0]   i_key_char,
    input  logic                               i_key_last,
    output chrr_pkg::t_pos                     o_pos
);

    chrr_pkg::t_pos      r_hash;
    chrr_pkg::t_pos      n_hash;
    chrr_pkg::t_hash_sum sum;

    // reduce by ring size with a short restoring chain
    always_comb begin
        sum = chrr_pkg::t_hash_sum'(r_hash) * chrr_pkg::t_hash_sum'(chrr_pkg::HashMult)
            + chrr_pkg::t_hash_sum'(i_key_char);
        for (int k = chrr_pkg::HashSteps - 1; k >= 0; k--) begin
            if (sum >= (chrr_pkg::t_hash_sum'(chrr_pkg::RingPositions) << k)) begin
                sum = sum - (chrr_pkg::t_hash_sum'(chrr_pkg::RingPositions) << k);
            end
        end
    end

    assign o_pos = chrr_pkg::t_pos'(sum);

    always_comb begin
        n_hash = r_hash;
        if (i_accept) begin
            n_hash = i_key_last ? '0 : o_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/chrr_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ring router ring controller
// occupancy words and server ids in ram, read-modify-write and wrapped search
// ---------------------------------------------------------------------------
`include "consistent_hash_ring_router_core_macros.svh"
module chrr_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  chrr_pkg::t_pos      i_pos,
    input  chrr_pkg::t_mode     i_mode,
    input  chrr_pkg::t_sid      i_sid,
    input  logic                i_res_take,
    output logic                o_busy,
    output logic                o_res_valid,
    output chrr_pkg::t_result   o_res
);

    chrr_pkg::t_state   r_state;
    chrr_pkg::t_state   n_state;
    chrr_pkg::t_pos     r_pos;
    chrr_pkg::t_pos     n_pos;
    chrr_pkg::t_mode    r_mode;
    chrr_pkg::t_mode    n_mode;
    chrr_pkg::t_sid     r_sid;
    chrr_pkg::t_sid     n_sid;
    chrr_pkg::t_summary r_summary;
    chrr_pkg::t_summary n_summary;
    chrr_pkg::t_row     r_next_row;
    chrr_pkg::t_row     n_next_row;
    chrr_pkg::t_result  r_res;
    chrr_pkg::t_result  n_res;

    logic                occ_we;
    chrr_pkg::t_row      occ_waddr;
    chrr_pkg::t_row_word occ_wdata;
    chrr_pkg::t_row      occ_raddr;
    chrr_pkg::t_row_word occ_rdata;
    logic                srv_we;
    chrr_pkg::t_pos      srv_waddr;
    chrr_pkg::t_sid      srv_wdata;
    chrr_pkg::t_pos      srv_raddr;
    chrr_pkg::t_sid      srv_rdata;

    chrr_pkg::t_row      cur_row;
    chrr_pkg::t_row_bit  cur_bit;
    chrr_pkg::t_row_word row_q;
    chrr_pkg::t_row_word bit_mask;
    chrr_pkg::t_row_word masked;
    chrr_pkg::t_row_word cleared;
    chrr_pkg::t_row      next_row;
    chrr_pkg::t_row_cand cand;
    logic                any_occ;

    chrr_ram #(
        .Width (chrr_pkg::RowBits),
        .Depth (chrr_pkg::NumRows)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    chrr_ram #(
        .Width (chrr_pkg::ServerIdBits),
        .Depth (chrr_pkg::RingPositions)
    ) u_srv_ram (
        .i_clk   (i_clk),
        .i_we    (srv_we),
        .i_waddr (srv_waddr),
        .i_wdata (srv_wdata),
        .i_raddr (srv_raddr),
        .o_rdata (srv_rdata)
    );

    assign cur_row  = chrr_pkg::pos_row(r_pos);
    assign cur_bit  = chrr_pkg::pos_bit(r_pos);
    // a row never marked non-empty reads as all free, so no clearing pass
    assign row_q    = r_summary[cur_row] ? occ_rdata : '0;
    assign bit_mask = chrr_pkg::t_row_word'(1) << cur_bit;
    assign masked   = row_q & (~chrr_pkg::t_row_word'(0) << cur_bit);
    assign cleared  = row_q & ~bit_mask;
    assign any_occ  = |r_summary;

    // first non-empty row after the current one, wrapping round to itself
    always_comb begin
        next_row = cur_row;
        cand     = '0;
        for (int i = chrr_pkg::NumRows; i >= 1; i--) begin
            cand = chrr_pkg::t_row_cand'(cur_row) + chrr_pkg::t_row_cand'(i);
            if (cand >= chrr_pkg::t_row_cand'(chrr_pkg::NumRows)) begin
                cand = cand - chrr_pkg::t_row_cand'(chrr_pkg::NumRows);
            end
            if (r_summary[chrr_pkg::t_row'(cand)]) begin
                next_row = chrr_pkg::t_row'(cand);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chrr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = chrr_pkg::ST_READ;
                end
            end
            chrr_pkg::ST_READ: begin
                n_state = chrr_pkg::ST_EVAL;
            end
            chrr_pkg::ST_EVAL: begin
                if (r_mode == chrr_pkg::MODE_LOOKUP) begin
                    if ((|masked) || (any_occ && (next_row == cur_row))) begin
                        n_state = chrr_pkg::ST_SRV;
                    end else if (any_occ) begin
                        n_state = chrr_pkg::ST_ROW2;
                    end else begin
                        n_state = chrr_pkg::ST_RESULT;
                    end
                end else begin
                    n_state = chrr_pkg::ST_RESULT;
                end
            end
            chrr_pkg::ST_ROW2: begin
                n_state = chrr_pkg::ST_SRV;
            end
            chrr_pkg::ST_SRV: begin
                n_state = chrr_pkg::ST_RESULT;
            end
            chrr_pkg::ST_RESULT: begin
                if (i_res_take) begin
                    n_state = chrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = chrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_sid      = r_sid;
        n_summary  = r_summary;
        n_next_row = r_next_row;
        n_res      = r_res;
        occ_we     = 1'b0;
        occ_waddr  = cur_row;
        occ_wdata  = row_q;
        occ_raddr  = cur_row;
        srv_we     = 1'b0;
        srv_waddr  = r_pos;
        srv_wdata  = r_sid;
        srv_raddr  = chrr_pkg::row_pos(cur_row, chrr_pkg::first_set(masked));
        unique case (r_state) inside
            chrr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_pos        = i_pos;
                    n_mode       = i_mode;
                    n_sid        = i_sid;
                    n_res.found  = 1'b0;
                    n_res.target = '0;
                    n_res.pos    = i_pos;
                end
            end
            chrr_pkg::ST_EVAL: begin
                case (r_mode)
                    chrr_pkg::MODE_ADD: begin
                        occ_we             = 1'b1;
                        occ_wdata          = row_q | bit_mask;
                        n_summary[cur_row] = 1'b1;
                        srv_we             = 1'b1;
                    end
                    chrr_pkg::MODE_REMOVE: begin
                        occ_we             = 1'b1;
                        occ_wdata          = cleared;
                        n_summary[cur_row] = |cleared;
                    end
                    chrr_pkg::MODE_LOOKUP: begin
                        if (!(|masked)) begin
                            if (next_row == cur_row) begin
                                // only this row holds servers, all below the key
                                srv_raddr = chrr_pkg::row_pos(cur_row,
                                                              chrr_pkg::first_set(row_q));
                            end else begin
                                occ_raddr  = next_row;
                                n_next_row = next_row;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            chrr_pkg::ST_ROW2: begin
                srv_raddr = chrr_pkg::row_pos(r_next_row, chrr_pkg::first_set(occ_rdata));
            end
            chrr_pkg::ST_SRV: begin
                n_res.found  = 1'b1;
                n_res.target = srv_rdata;
            end
            chrr_pkg::ST_READ, chrr_pkg::ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= chrr_pkg::ST_IDLE;
            r_summary <= '0;
        end else begin
            r_state   <= n_state;
            r_summary <= n_summary;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_mode     <= n_mode;
        r_sid      <= n_sid;
        r_next_row <= n_next_row;
        r_res      <= n_res;
    end

    assign o_busy      = (r_state != chrr_pkg::ST_IDLE);
    assign o_res_valid = (r_state == chrr_pkg::ST_RESULT);
    assign o_res       = r_res;

    `CHRR_ASSERT_SAME(a_start_idle, i_clk, i_rst_n, i_start, r_state == chrr_pkg::ST_IDLE)
    `CHRR_ASSERT_SAME(a_take_result, i_clk, i_rst_n, i_res_take, r_state == chrr_pkg::ST_RESULT)
    `CHRR_ASSERT_SAME(a_found_lookup, i_clk, i_rst_n, (r_state == chrr_pkg::ST_RESULT) && r_res.found, (r_mode == chrr_pkg::MODE_LOOKUP) && any_occ)
    `CHRR_ASSERT_SAME(a_row2_nonempty, i_clk, i_rst_n, r_state == chrr_pkg::ST_ROW2, |occ_rdata)
    `CHRR_ASSERT_NEXT(a_add_marks_row, i_clk, i_rst_n, (r_state == chrr_pkg::ST_EVAL) && (r_mode == chrr_pkg::MODE_ADD), r_summary[cur_row])

endmodule
`default_nettype wire

[hw/rtl/consistent_hash_ring_router_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// consistent hash ring router core
// key bytes in, one routing result per finished key out
// ---------------------------------------------------------------------------
// input channel: one key byte per item with mode, last marker and server id;
// mode and server id count only on the byte marked last.
// output channel: target server, found flag and key ring position, one item
// for every last byte, none for the others.
// a byte that is not last goes into the hash register whenever the controller is idle.
// a last byte stalls the input until the controller is idle again; its states are:
//   add, remove, unused mode, empty ring: read, eval, result
//   lookup hit in the key's own occupancy word, wrapping or not: read, eval, srv, result
//   lookup that moves to another occupancy word: read, eval, row2, srv, result
// the occupancy ram read-modify-write and the server id ram read set these
// states; the result state holds until the output register takes the result.
// reset clears the running hash and the per-word occupancy flags, so the ring
// is empty at once and no clearing pass is needed.
// a stalled result waits in the output register; key bytes keep flowing, and
// the next finished key waits in the controller until that register frees.
// ---------------------------------------------------------------------------
module consistent_hash_ring_router_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_mode,
    input  logic [chrr_pkg::KeyCharBits-1:0]   i_key_char,
    input  logic                               i_key_last,
    input  logic [chrr_pkg::SidPortBits-1:0]   i_server_id,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [chrr_pkg::SidPortBits-1:0]   o_target_server,
    output logic                               o_found,
    output logic [chrr_pkg::PosPortBits-1:0]   o_key_position
);

    logic              accept;
    logic              start;
    logic              ring_busy;
    logic              res_valid;
    logic              res_take;
    chrr_pkg::t_pos    hash_pos;
    chrr_pkg::t_result res;
    chrr_pkg::t_result r_out;
    logic              r_out_valid;
    logic              n_out_valid;

    assign o_in_stall = ring_busy;
    assign accept     = i_in_valid && !ring_busy;
    assign start      = accept && i_key_last;

    chrr_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_key_char (i_key_char),
        .i_key_last (i_key_last),
        .o_pos      (hash_pos)
    );

    chrr_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_pos       (hash_pos),
        .i_mode      (chrr_pkg::t_mode'(i_mode)),
        .i_sid       (chrr_pkg::t_sid'(i_server_id)),
        .i_res_take  (res_take),
        .o_busy      (ring_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register frees when empty or when its item goes this cycle
    assign res_take    = res_valid && (!r_out_valid || !i_out_stall);
    assign n_out_valid = res_take || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_target_server = chrr_pkg::SidPortBits'(r_out.target);
    assign o_found         = r_out.found;
    assign o_key_position  = chrr_pkg::PosPortBits'(r_out.pos);

endmodule
`default_nettype wire
